// ===== rtl/binary_trie_max_xor_macros.svh =====
// Assertion macros used by the binary trie max-XOR datapath.
`ifndef BINARY_TRIE_MAX_XOR_MACROS_SVH
`define BINARY_TRIE_MAX_XOR_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled while in reset.
`define BTMX_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication, disabled while in reset.
`define BTMX_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define BTMX_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define BTMX_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

// ===== rtl/btmx_pkg.sv =====
// Package: types, codes and defaults for the binary trie max-XOR block.
package btmx_pkg;

  localparam int KEY_W          = 40;
  localparam int STATUS_W       = 2;
  localparam int DEF_KEY_BITS   = 40;
  localparam int DEF_MAX_NODES  = 4096;

  typedef enum logic {
    REQ_INSERT = 1'b0,
    REQ_QUERY  = 1'b1
  } req_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK     = 2'd0,
    STAT_EMPTY  = 2'd1,
    STAT_REJECT = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_DONE
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic start;
    logic step;
    logic load_out;
  } ctl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic skip;
    logic walk_done;
    logic out_free;
  } dp_stat_t;

endpackage

// ===== rtl/btmx_if.sv =====
// Valid/ready channel interfaces for request and result beats.
interface btmx_in_if import btmx_pkg::*; ();
  logic             valid;
  logic             ready;
  req_t             req_type;
  logic [KEY_W-1:0] key_value;

  modport source (output valid, output req_type, output key_value, input ready);
  modport sink   (input valid, input req_type, input key_value, output ready);
endinterface

interface btmx_out_if import btmx_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [KEY_W-1:0] max_xor;
  status_t          status;

  modport source (output valid, output max_xor, output status, input ready);
  modport sink   (input valid, input max_xor, input status, output ready);
endinterface

// ===== rtl/btmx_ctrl.sv =====
// Sequencer for the trie walk: accept, one level per cycle, hand off result.
module btmx_ctrl import btmx_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  dp_stat_t stat,
  output ctl_cmd_t cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = stat.skip ? ST_DONE : ST_WALK;
      end
      ST_WALK: begin
        if (stat.walk_done) state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (stat.out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready     = 1'b0;
    cmd          = '0;
    case (state_r)
      ST_IDLE: begin
        in_ready  = 1'b1;
        cmd.start = in_valid;
      end
      ST_WALK: begin
        cmd.step = 1'b1;
      end
      ST_DONE: begin
        cmd.load_out = stat.out_free;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

// ===== rtl/btmx_datapath.sv =====
// Trie datapath: node store, walk registers, node allocator, result register.
`include "binary_trie_max_xor_macros.svh"
module btmx_datapath import btmx_pkg::*; #(
  parameter int KEY_BITS  = DEF_KEY_BITS,
  parameter int MAX_NODES = DEF_MAX_NODES
) (
  input  logic             clk,
  input  logic             rst_n,
  input  ctl_cmd_t         cmd,
  output dp_stat_t         stat,
  input  req_t             in_req_type,
  input  logic [KEY_W-1:0] in_key_value,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [KEY_W-1:0] out_max_xor,
  output status_t          out_status
);

  localparam int IDX_W = $clog2(MAX_NODES);
  localparam int CNT_W = $clog2(MAX_NODES + 1);
  localparam int POS_W = (KEY_BITS > 1) ? $clog2(KEY_BITS) : 1;
  localparam int EXT_W = (KEY_BITS > KEY_W) ? KEY_BITS : KEY_W;
  localparam int LNK_W = 2 * IDX_W;

  // node store; entry 0 (root) lives in root_r so reset can clear it
  logic [LNK_W-1:0] node_mem_r [MAX_NODES];
  logic [LNK_W-1:0] rd_data_r;
  logic [LNK_W-1:0] root_r;

  logic [CNT_W-1:0] nodes_used_r;
  logic [IDX_W-1:0] cur_r;
  logic [POS_W-1:0] pos_r;
  logic [EXT_W-1:0] key_r;
  logic [EXT_W-1:0] acc_r;
  req_t             req_r;
  logic             fresh_r;
  status_t          status_r;

  logic             out_valid_r;
  logic [KEY_W-1:0] out_max_r;
  status_t          out_status_r;

  logic [LNK_W-1:0] cur_links;
  logic [IDX_W-1:0] lnk0, lnk1, own, opp, child, new_idx, rd_addr;
  logic             bit_b, miss, take_opp, dead, is_ins;
  logic [LNK_W-1:0] wr_data;
  logic [CNT_W-1:0] free_cnt;
  logic             full, empty;
  status_t          start_status;

  // ---- admission checks on the incoming beat
  assign free_cnt = CNT_W'(MAX_NODES) - nodes_used_r;
  assign full     = free_cnt < CNT_W'(KEY_BITS);
  assign empty    = nodes_used_r <= CNT_W'(1);

  always_comb begin
    start_status = STAT_OK;
    if (in_req_type == REQ_INSERT) begin
      if (full) start_status = STAT_REJECT;
    end else begin
      if (empty) start_status = STAT_EMPTY;
    end
  end

  // ---- one trie level
  assign cur_links = (cur_r == '0) ? root_r : (fresh_r ? '0 : rd_data_r);
  assign lnk0      = cur_links[IDX_W-1:0];
  assign lnk1      = cur_links[LNK_W-1:IDX_W];
  assign bit_b     = key_r[pos_r];
  assign own       = bit_b ? lnk1 : lnk0;
  assign opp       = bit_b ? lnk0 : lnk1;
  assign is_ins    = (req_r == REQ_INSERT);
  assign new_idx   = nodes_used_r[IDX_W-1:0];
  assign miss      = (own == '0);
  assign take_opp  = (opp != '0);
  assign dead      = !take_opp && miss;
  assign wr_data   = bit_b ? {new_idx, lnk0} : {lnk1, new_idx};

  always_comb begin
    if (is_ins) begin
      child = miss ? new_idx : own;
    end else begin
      child = take_opp ? opp : own;
    end
  end

  assign rd_addr = child;

  assign stat.skip      = (start_status != STAT_OK);
  assign stat.walk_done = (pos_r == '0) || (!is_ins && dead);
  assign stat.out_free  = !out_valid_r || out_ready;

  // node store: one write, one registered read per cycle
  always_ff @(posedge clk) begin
    if (cmd.step && is_ins && miss && (cur_r != '0)) begin
      node_mem_r[cur_r] <= wr_data;
    end
    rd_data_r <= node_mem_r[rd_addr];
  end

  // control state and allocator
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      root_r       <= '0;
      nodes_used_r <= CNT_W'(1);
      out_valid_r  <= 1'b0;
    end else begin
      if (cmd.step && is_ins && miss) begin
        nodes_used_r <= nodes_used_r + CNT_W'(1);
        if (cur_r == '0) root_r <= wr_data;
      end
      if (cmd.load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // walk payload
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      req_r    <= in_req_type;
      key_r    <= EXT_W'(in_key_value);
      cur_r    <= '0;
      pos_r    <= POS_W'(KEY_BITS - 1);
      acc_r    <= '0;
      fresh_r  <= 1'b0;
      status_r <= start_status;
    end else if (cmd.step) begin
      cur_r   <= child;
      pos_r   <= pos_r - POS_W'(1);
      fresh_r <= is_ins && (fresh_r || miss);
      if (!is_ins && take_opp) acc_r[pos_r] <= 1'b1;
    end
    if (cmd.load_out) begin
      out_max_r    <= acc_r[KEY_W-1:0];
      out_status_r <= status_r;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_max_xor = out_max_r;
  assign out_status  = out_status_r;

  `BTMX_ASSERT_IMP(a_used_range, clk, rst_n, 1'b1, (nodes_used_r != '0) && (nodes_used_r <= CNT_W'(MAX_NODES)), "node count out of range")
  `BTMX_ASSERT_NXT(a_alloc_only_on_insert, clk, rst_n, !(cmd.step && is_ins), $stable(nodes_used_r), "node count moved outside an insert walk")
  `BTMX_ASSERT_IMP(a_non_ok_is_zero, clk, rst_n, out_valid_r && (out_status_r != STAT_OK), out_max_r == '0, "nonzero result with non-ok status")
  `BTMX_ASSERT_IMP(a_step_exclusive, clk, rst_n, cmd.step, !cmd.start && !cmd.load_out, "walk step overlaps start or result load")

endmodule

// ===== rtl/binary_trie_max_xor.sv =====
// Top level of the binary trie maximum-XOR engine.
// Keeps a binary trie of KEY_BITS-bit keys in a MAX_NODES-entry node store
// (node 0 is the root, held in flops so reset clears it; other entries are
// written on allocation and need no clearing pass). A request beat with
// req_type insert walks the key from its top bit, allocating missing nodes;
// one with req_type query walks the same way, preferring the branch opposite
// to each key bit, and returns the largest XOR against any stored key. Every
// request produces exactly one result beat. Status: ok; empty (query on an
// empty trie, result zero); reject (insert with fewer than KEY_BITS free
// nodes, trie unchanged, result zero). Inserts return zero. Timing: one trie
// level per clock through the node store's single registered read port; empty
// and rejected requests skip the walk and go straight to the result register.
// One request is in flight at a time. Results sit in an output register, so
// the next request is accepted while a result beat still waits for ready.
module binary_trie_max_xor import btmx_pkg::*; #(
  parameter int KEY_BITS  = DEF_KEY_BITS,   // trie depth, 1..64
  parameter int MAX_NODES = DEF_MAX_NODES   // node store entries, 64..1M
) (
  input logic         clk,
  input logic         rst_n,
  btmx_in_if.sink     in_ch,
  btmx_out_if.source  out_ch
);

  ctl_cmd_t cmd;    // sequencer commands
  dp_stat_t stat;   // datapath status back to the sequencer

  // sequencer: idle / walk / result hand-off
  btmx_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // node store, walk registers and result register
  btmx_datapath #(
    .KEY_BITS  (KEY_BITS),
    .MAX_NODES (MAX_NODES)
  ) u_datapath (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .stat         (stat),
    .in_req_type  (in_ch.req_type),
    .in_key_value (in_ch.key_value),
    .out_valid    (out_ch.valid),
    .out_ready    (out_ch.ready),
    .out_max_xor  (out_ch.max_xor),
    .out_status   (out_ch.status)
  );

endmodule

// ===== sim/binary_trie_max_xor_test.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for binary_trie_max_xor: trie mirror, random traffic, backpressure.
import btmx_pkg::*;

// One expected result beat.
typedef struct {
  logic [KEY_W-1:0] max_xor;
  status_t          status;
} trie_result_t;

// Mirrors the node store and checks result beats in order.
class trie_xor_tracker;
  int unsigned  links [DEF_MAX_NODES][2];
  int unsigned  nodes_used;
  trie_result_t expected_q[$];
  int           n_checked, n_errors, n_inserted, n_rejected, n_queried, n_empty;

  function new();
    nodes_used = 1;
  endfunction

  // Inserts need KEY_BITS free entries, whether or not the key is new.
  function bit store_full();
    return int'(DEF_MAX_NODES) - int'(nodes_used) < DEF_KEY_BITS;
  endfunction

  function void note_request(req_t req, logic [KEY_W-1:0] key_val);
    trie_result_t res;
    int unsigned  node;
    logic         b;
    res.max_xor = '0;
    res.status  = STAT_OK;
    node        = 0;
    if (req == REQ_INSERT) begin
      if (store_full()) begin
        res.status = STAT_REJECT;
        n_rejected++;
      end else begin
        n_inserted++;
        for (int lvl = DEF_KEY_BITS - 1; lvl >= 0; lvl--) begin
          b = key_val[lvl];
          if (links[node][b] == 0) begin
            links[nodes_used][0] = 0;
            links[nodes_used][1] = 0;
            links[node][b]       = nodes_used;
            nodes_used++;
          end
          node = links[node][b];
        end
      end
    end else if (nodes_used <= 1) begin
      res.status = STAT_EMPTY;
      n_empty++;
    end else begin
      n_queried++;
      // greedy walk: opposite branch first
      for (int lvl = DEF_KEY_BITS - 1; lvl >= 0; lvl--) begin
        b = key_val[lvl];
        if (links[node][!b] != 0) begin
          res.max_xor[lvl] = 1'b1;
          node = links[node][!b];
        end else if (links[node][b] != 0) begin
          node = links[node][b];
        end else begin
          break;
        end
      end
    end
    expected_q.push_back(res);
  endfunction

  function void log_mismatch(string msg);
    n_errors++;
    if (n_errors <= 100) $display("%0t: %s", $time, msg);
    if (n_errors == 100) $display("%0t: further mismatches are counted only", $time);
  endfunction

  function void check_result(logic [KEY_W-1:0] got_xor, status_t got_status);
    trie_result_t want;
    if (expected_q.size() == 0) begin
      log_mismatch($sformatf("unexpected result beat: expected none, got max_xor %h status %0d",
                             got_xor, got_status));
      return;
    end
    want = expected_q.pop_front();
    n_checked++;
    if (got_xor !== want.max_xor)
      log_mismatch($sformatf("max_xor mismatch: expected %h, got %h", want.max_xor, got_xor));
    if (got_status !== want.status)
      log_mismatch($sformatf("status mismatch: expected %0d, got %0d", want.status, got_status));
  endfunction
endclass

module binary_trie_max_xor_test;

  localparam int     CLK_HALF      = 6;
  localparam int     RESET_CYCLES  = 10;
  // drain time after the last beat, scaled from the walk length
  localparam int     DRAIN_CYCLES  = 3 * (DEF_KEY_BITS + 2);
  localparam int     PHASE_A_ITEMS = 950;
  localparam int     PHASE_B_ITEMS = 900;
  localparam int     LONG_HOLD     = 600;
  // watchdog timeout, set well above the slowest legal run
  localparam longint LIMIT_NS      = 64'd12 * 64'd1_200_000;
  localparam int     N_PREFIX      = 6;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  btmx_in_if  in_ch ();
  btmx_out_if out_ch ();

  binary_trie_max_xor dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  trie_xor_tracker tracker = new();

  // Cluster prefixes: keys sharing a long top part cost few new nodes each,
  // so many more inserts land before the store runs out.
  logic [KEY_W-1:0] prefixes [N_PREFIX];
  logic [KEY_W-1:0] sent_keys[$];

  // calm stretches: no random gaps on that side while set (long hold-offs still apply)
  bit send_calm = 1'b0;
  bit recv_calm = 1'b0;
  // result count at which the receiver starts its next long hold-off
  int hold_at   = 200;

  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  // Mostly short gaps, now and then a long one.
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [KEY_W-1:0] rand_key();
    logic [63:0] r;
    r = {$urandom(), $urandom()};
    return r[KEY_W-1:0];
  endfunction

  // Offer one request beat at the falling edge and hold it until accepted.
  // Valid stays high into the next call, so back-to-back beats need no gap.
  task automatic send_req(req_t req, logic [KEY_W-1:0] key_val);
    int gap;
    if ($urandom_range(0, 99) == 0) send_calm = !send_calm;
    gap = (send_calm || $urandom_range(0, 99) < 55) ? 0 : gap_len();
    repeat (gap) begin
      @(negedge clk);
      in_ch.valid = 1'b0;
    end
    @(negedge clk);
    in_ch.valid     = 1'b1;
    in_ch.req_type  = req;
    in_ch.key_value = key_val;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    tracker.note_request(req, key_val);
    if (req == REQ_INSERT) sent_keys.push_back(key_val);
  endtask

  // Random beat: inserts lean on clustered keys and repeats, queries mix
  // fully random keys with keys close to ones already sent.
  task automatic send_random();
    int               r;
    int               w;
    logic [KEY_W-1:0] k;
    logic [KEY_W-1:0] mask;
    logic [KEY_W-1:0] ones;
    ones = '1;
    w    = $urandom_range(2, 10);
    mask = ones >> (KEY_W - w);
    r    = $urandom_range(0, 99);
    if ($urandom_range(0, 1) == 0) begin
      if (r < 60)
        k = (prefixes[$urandom_range(0, N_PREFIX - 1)] & ~mask) | (rand_key() & mask);
      else if (r < 80 && sent_keys.size() > 0)
        k = sent_keys[$urandom_range(0, sent_keys.size() - 1)];
      else
        k = rand_key();
      send_req(REQ_INSERT, k);
    end else begin
      if (r < 50 || sent_keys.size() == 0)
        k = rand_key();
      else if (r < 75)
        k = sent_keys[$urandom_range(0, sent_keys.size() - 1)] ^ (rand_key() & mask);
      else
        k = (prefixes[$urandom_range(0, N_PREFIX - 1)] & ~mask) | (rand_key() & mask);
      send_req(REQ_QUERY, k);
    end
  endtask

  // Receiver ready: random stalls, calm stretches, and long hold-offs that
  // fill the output register and the walk behind it, stalling the input.
  initial begin
    int stall_left;
    stall_left   = 0;
    out_ch.ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      if (tracker.n_checked >= hold_at) begin
        stall_left = LONG_HOLD;
        hold_at    = (hold_at < 1000) ? 1300 : 32'h7fff_ffff;
      end
      if ($urandom_range(0, 149) == 0) recv_calm = !recv_calm;
      if (stall_left > 0) begin
        out_ch.ready = 1'b0;
        stall_left--;
      end else if (!recv_calm && $urandom_range(0, 99) < 30) begin
        out_ch.ready = 1'b0;
        stall_left   = gap_len() - 1;
      end else begin
        out_ch.ready = 1'b1;
      end
    end
  end

  // Result beats are sampled at the rising edge; ready was set at the fall.
  always @(posedge clk) begin
    if (rst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1)
      tracker.check_result(out_ch.max_xor, out_ch.status);
  end

  initial begin
    #(LIMIT_NS);
    $display("Timed out at %0t with %0d results outstanding",
             $time, tracker.expected_q.size());
    $display("** binary_trie_max_xor: FAILED **");
    $finish;
  end

  initial begin
    in_ch.valid     = 1'b0;
    in_ch.req_type  = REQ_INSERT;
    in_ch.key_value = '0;
    foreach (prefixes[i]) prefixes[i] = rand_key();
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n = 1'b1;

    // --- directed ---
    // queries before anything is stored come back empty
    send_req(REQ_QUERY,  40'h00_0000_0000);
    send_req(REQ_QUERY,  40'hFF_FFFF_FFFF);
    // the two extreme keys, then a duplicate
    send_req(REQ_INSERT, 40'h00_0000_0000);
    send_req(REQ_INSERT, 40'hFF_FFFF_FFFF);
    send_req(REQ_INSERT, 40'h00_0000_0000);
    send_req(REQ_QUERY,  40'h00_0000_0000);
    send_req(REQ_QUERY,  40'hFF_FFFF_FFFF);
    send_req(REQ_QUERY,  40'h80_0000_0000);
    send_req(REQ_QUERY,  40'h00_0000_0001);
    // alternating patterns
    send_req(REQ_INSERT, 40'hAA_AAAA_AAAA);
    send_req(REQ_INSERT, 40'h55_5555_5555);
    send_req(REQ_QUERY,  40'hAA_AAAA_AAAA);
    send_req(REQ_QUERY,  40'h0F_0F0F_0F0F);
    // keys that differ from stored ones only in the lowest bit
    send_req(REQ_INSERT, 40'h00_0000_0001);
    send_req(REQ_INSERT, 40'hFF_FFFF_FFFE);
    send_req(REQ_QUERY,  40'h00_0000_0001);
    send_req(REQ_QUERY,  40'hFF_FFFF_FFFE);
    send_req(REQ_QUERY,  40'h7F_FFFF_FFFF);

    // --- random, store filling up ---
    repeat (PHASE_A_ITEMS) send_random();

    // make sure the store is past the reject threshold
    while (!tracker.store_full()) send_req(REQ_INSERT, rand_key());
    // a key already stored is still turned away once the store is full
    send_req(REQ_INSERT, 40'h00_0000_0000);
    send_req(REQ_INSERT, 40'hFF_FFFF_FFFF);
    send_req(REQ_QUERY,  40'h00_0000_0000);

    // --- random, store full: rejects and deep queries ---
    repeat (PHASE_B_ITEMS) send_random();

    @(negedge clk);
    in_ch.valid = 1'b0;

    while (tracker.expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Stored %0d keys, turned away %0d inserts on a full store, answered %0d queries",
             tracker.n_inserted, tracker.n_rejected, tracker.n_queried);
    $display("and %0d empty-trie queries; %0d of %0d nodes used, %0d result beats checked.",
             tracker.n_empty, tracker.nodes_used, DEF_MAX_NODES, tracker.n_checked);
    if (tracker.n_errors == 0) begin
      $display("** binary_trie_max_xor: PASSED **");
    end else begin
      $display("%0d mismatches", tracker.n_errors);
      $display("** binary_trie_max_xor: FAILED **");
    end
    $finish;
  end

endmodule

// ===== binary_trie_max_xor.f =====
+incdir+rtl
rtl/btmx_pkg.sv
rtl/btmx_if.sv
rtl/btmx_ctrl.sv
rtl/btmx_datapath.sv
rtl/binary_trie_max_xor.sv
sim/binary_trie_max_xor_test.sv
